FILE: sv/lmdl_pkg.sv
// Shared types and constants of the modulated delay line.
`timescale 1ns / 1ps
package lmdl_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 19;
    localparam int PHASE_W  = 32;
    localparam int SINE_W   = 15;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 4;

    localparam logic [1:0] REG_BASE_DELAY   = 2'd0;
    localparam logic [1:0] REG_DEPTH_AMOUNT = 2'd1;
    localparam logic [1:0] REG_PHASE_STEP   = 2'd2;

    localparam logic [DELAY_W-1:0] BASE_DELAY_RST   = 19'd128000;
    localparam logic [DELAY_W-1:0] DEPTH_AMOUNT_RST = 19'd25600;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 32'd447392;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic [DELAY_W-1:0] base_delay;
        logic [DELAY_W-1:0] depth_amount;
        logic [PHASE_W-1:0] phase_step;
    } lmdl_cfg_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic look;
        logic prod;
        logic access;
        logic out_load;
    } lmdl_cmd_t;

    typedef struct packed {
        logic out_free;
    } lmdl_stat_t;

endpackage

FILE: sv/lfo_modulated_delay_line_top.sv
// Top level of the sine-LFO modulated delay line (vibrato effect).
// A sample transaction runs through index multiply, sine table lookup, depth multiply, one
// memory read and write, and output load, and the next transaction is accepted only after
// its result is loaded, so a new sample is not taken before the last one is through. A clear
// transaction goes straight to the output load of its zero result, after which the next one
// can be accepted. The sequence is set by the registered multiplier stages and the memory
// access, which reads the delayed sample and writes the new one in the same cycle. No
// clearing pass is needed after reset or a clear: a fill mark makes memory entries not yet
// written read as zero, and item_ready rises in the cycle after reset is released. The result
// register lets a new transaction be accepted while the previous result still waits to be
// taken; that transaction then holds in its output stage until the result register is
// free.
`timescale 1ns / 1ps
module lfo_modulated_delay_line_top
#(
    parameter int BUF_DEPTH            = 2048,
    parameter int SINE_QUARTER_ENTRIES = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lmdl_pkg::ADDR_W-1:0]          paddr,
    input  logic [lmdl_pkg::DATA_W-1:0]          pwdata,
    output logic [lmdl_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  logic                                 command,
    input  logic signed [lmdl_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [lmdl_pkg::SAMPLE_W-1:0] sample_out
);
    import lmdl_pkg::*;

    lmdl_cfg_t  cfg;
    lmdl_cmd_t  cmd;
    lmdl_stat_t stat;

    lmdl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lmdl_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .command    (command),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    lmdl_dp
    #(
        .BUF_DEPTH            (BUF_DEPTH),
        .SINE_QUARTER_ENTRIES (SINE_QUARTER_ENTRIES)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .sample_in    (sample_in),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .sample_out   (sample_out)
    );

endmodule

FILE: sv/lmdl_cfg.sv
// Configuration register bank behind the APB-style port.
`timescale 1ns / 1ps
module lmdl_cfg
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [lmdl_pkg::ADDR_W-1:0] paddr,
    input  logic [lmdl_pkg::DATA_W-1:0] pwdata,
    output logic [lmdl_pkg::DATA_W-1:0] prdata,
    output logic                    pready,
    output lmdl_pkg::lmdl_cfg_t     cfg
);
    import lmdl_pkg::*;

    logic [DELAY_W-1:0] base_delay_reg;
    logic [DELAY_W-1:0] depth_amount_reg;
    logic [PHASE_W-1:0] phase_step_reg;
    logic [1:0]         reg_index;
    logic               write_en;

    assign reg_index = paddr[ADDR_W-1:2];
    assign write_en  = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_delay_reg   <= BASE_DELAY_RST;
            depth_amount_reg <= DEPTH_AMOUNT_RST;
            phase_step_reg   <= PHASE_STEP_RST;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_BASE_DELAY:   base_delay_reg   <= pwdata[DELAY_W-1:0];
                REG_DEPTH_AMOUNT: depth_amount_reg <= pwdata[DELAY_W-1:0];
                REG_PHASE_STEP:   phase_step_reg   <= pwdata[PHASE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_BASE_DELAY:   prdata = DATA_W'(base_delay_reg);
            REG_DEPTH_AMOUNT: prdata = DATA_W'(depth_amount_reg);
            REG_PHASE_STEP:   prdata = DATA_W'(phase_step_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.base_delay   = base_delay_reg;
    assign cfg.depth_amount = depth_amount_reg;
    assign cfg.phase_step   = phase_step_reg;

endmodule

FILE: sv/lmdl_ctrl.sv
// Sequencing state machine for one transaction of the delay line.
`timescale 1ns / 1ps
module lmdl_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic                 command,
    output logic                 item_ready,
    input  lmdl_pkg::lmdl_stat_t stat,
    output lmdl_pkg::lmdl_cmd_t  cmd
);
    import lmdl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_PROD,
        S_ACCESS,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   accept;

    assign accept = item_valid && ready_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = command ? S_OUT : S_LOOK;
                end
            end
            S_LOOK:   state_next = S_PROD;
            S_PROD:   state_next = S_ACCESS;
            S_ACCESS: state_next = S_OUT;
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

    assign item_ready   = ready_reg;
    assign cmd.load     = accept && !command;
    assign cmd.clear    = accept && command;
    assign cmd.look     = (state_reg == S_LOOK);
    assign cmd.prod     = (state_reg == S_PROD);
    assign cmd.access   = (state_reg == S_ACCESS);
    assign cmd.out_load = (state_reg == S_OUT) && stat.out_free;

endmodule

FILE: sv/lmdl_dp.sv
// Datapath: sine LFO, delay arithmetic, circular sample memory and output register.
`timescale 1ns / 1ps
module lmdl_dp
#(
    parameter int BUF_DEPTH            = 2048,
    parameter int SINE_QUARTER_ENTRIES = 256
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lmdl_pkg::lmdl_cfg_t                  cfg,
    input  lmdl_pkg::lmdl_cmd_t                  cmd,
    output lmdl_pkg::lmdl_stat_t                 stat,
    input  logic signed [lmdl_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic signed [lmdl_pkg::SAMPLE_W-1:0] sample_out
);
    import lmdl_pkg::*;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int TW  = $clog2(SINE_QUARTER_ENTRIES + 1);
    localparam int T_W = 37;
    localparam logic [63:0] SQE64    = 64'(SINE_QUARTER_ENTRIES);
    localparam logic [63:0] HALF_SQE = 64'(SINE_QUARTER_ENTRIES / 2);
    localparam logic [TW-1:0] SQE    = TW'(SINE_QUARTER_ENTRIES);
    localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(BUF_DEPTH);
    localparam logic [31:0] MAX_DELAY = 32'(BUF_DEPTH - 1);

    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        x = (HALF_PI_Q30 * 64'(i) + HALF_SQE) / SQE64;
        term = x;
        sum = $signed(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k % 2 == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

    logic [SINE_W-1:0] sine_rom [0:SINE_QUARTER_ENTRIES];

    for (genvar g = 0; g <= SINE_QUARTER_ENTRIES; g++)
    begin : g_sine
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(g);
        assign sine_rom[g] = ENTRY;
    end

    logic signed [SAMPLE_W-1:0] mem [0:BUF_DEPTH-1];

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [TW-1:0]              tidx_reg;
    logic                       neg_reg;
    logic signed [SINE_W:0]     sine_reg;
    logic signed [T_W-1:0]      t_reg;
    logic [AW-1:0]              wi_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic                       full_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       result_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic [29+TW:0]        idx_prod;
    logic [TW-1:0]         idx;
    logic [SINE_W-1:0]     rom_value;
    logic signed [T_W-1:0] t_next;
    logic [T_W-1:0]        t_round;
    logic [31:0]           delay_wide;
    logic [AW-1:0]         delay;
    logic [AW:0]           diff;
    logic [AW-1:0]         raddr;
    logic                  raddr_valid;

    assign idx_prod  = (30 + TW)'(phase_reg[29:0]) * (30 + TW)'(SQE);
    assign idx       = idx_prod[30 +: TW];
    assign rom_value = sine_rom[tidx_reg];

    assign t_next = $signed(T_W'({cfg.base_delay, 15'd0}))
                  + $signed({1'b0, cfg.depth_amount}) * sine_reg;

    always_comb
    begin
        t_round    = $unsigned(t_reg) + T_W'(1 << 22);
        delay_wide = 32'(t_round[T_W-1:23]);
        if (t_reg < 0)
        begin
            delay_wide = '0;
        end
        if (delay_wide > MAX_DELAY)
        begin
            delay_wide = MAX_DELAY;
        end
        delay = delay_wide[AW-1:0];
        diff  = {1'b0, wi_reg} - {1'b0, delay};
        if (diff[AW])
        begin
            raddr = AW'(diff + DEPTH_EXT);
        end
        else
        begin
            raddr = diff[AW-1:0];
        end
        raddr_valid = full_reg || (raddr < wi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample_in;
            neg_reg    <= phase_reg[31];
            tidx_reg   <= phase_reg[30] ? SQE - idx : idx;
        end
        if (cmd.look)
        begin
            sine_reg <= neg_reg ? -$signed({1'b0, rom_value}) : $signed({1'b0, rom_value});
        end
        if (cmd.prod)
        begin
            t_reg <= t_next;
        end
        if (cmd.access)
        begin
            rd_data_reg  <= mem[raddr];
            mem[wi_reg]  <= sample_reg;
        end
        if (cmd.out_load)
        begin
            sample_out_reg <= rd_valid_reg ? rd_data_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg           <= '0;
            phase_reg        <= '0;
            full_reg         <= 1'b0;
            rd_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                wi_reg       <= '0;
                phase_reg    <= '0;
                full_reg     <= 1'b0;
                rd_valid_reg <= 1'b0;
            end
            else if (cmd.access)
            begin
                rd_valid_reg <= raddr_valid;
                phase_reg    <= phase_reg + cfg.phase_step;
                if (wi_reg == AW'(BUF_DEPTH - 1))
                begin
                    wi_reg   <= '0;
                    full_reg <= 1'b1;
                end
                else
                begin
                    wi_reg <= wi_reg + AW'(1);
                end
            end
            if (cmd.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.out_free = !result_valid_reg || result_ready;
    assign result_valid  = result_valid_reg;
    assign sample_out    = sample_out_reg;

endmodule

FILE: sv/lmdl_checker.sv
// Port-level assertions for the modulated delay line, bound to the top level.
`timescale 1ns / 1ps
module lmdl_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 pready,
    input logic                                 item_valid,
    input logic                                 item_ready,
    input logic                                 command,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic signed [lmdl_pkg::SAMPLE_W-1:0] sample_out
);

    // A pending result holds its value until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(sample_out))
    else $error("Pending result changed before it was taken.");

    // Only one transaction is in progress at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("Input ready after an accepted transaction.");

    // A result appears only after the input side has been busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready))
    else $error("Result appeared without a transaction in progress.");

    // A clear with a free output register yields a zero result, loaded in the output state into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && command && !result_valid
        |=> ##1 (result_valid && sample_out == '0))
    else $error("Clear did not produce a zero result.");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped.");

endmodule

bind lfo_modulated_delay_line_top lmdl_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sample_out   (sample_out)
);
